[sv/iopb_pkg.sv]
// package for the i/o port permission bitmap
// holds map size constants, operation codes and controller states; no dependencies

package iopb_pkg;

  // number of bytes in the bitmap, one bit per port
  localparam int BITMAP_BYTES = 8192;

  // port and byte index widths
  localparam int PORT_W = 16;
  localparam int PB_W   = PORT_W - 3;
  localparam int ADDR_W = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;

  // byte index limits
  localparam logic [PB_W:0]   MAP_LIMIT = (PB_W + 1)'(BITMAP_BYTES);
  localparam logic [PB_W-1:0] MAP_LAST  = PB_W'(BITMAP_BYTES - 1);

  // all ports denied
  localparam logic [7:0] BYTE_DENY = 8'hFF;

  // operation codes
  typedef enum logic [1:0] {
    FN_ALLOW = 2'd0,
    FN_DENY  = 2'd1,
    FN_QUERY = 2'd2,
    FN_CLEAR = 2'd3
  } iopb_func_t;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_QUERY,
    ST_DONE
  } iopb_state_t;

endpackage

[sv/io_port_permission_bitmap.sv]
// i/o port permission bitmap: one bit per port, set bit denies; depends on iopb_pkg
// byte memory with a read-modify-write range walker and a clearing sweep
// throughput: one word at a time; the walker covers one byte (eight ports) a cycle
// reset: sweep writes 0xFF to every byte, one a cycle, with in_ready low until it ends

module io_port_permission_bitmap
  import iopb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_func,
  input  logic [PORT_W-1:0] in_start_port,
  input  logic [PORT_W-1:0] in_end_port,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_allowed
);

  iopb_state_t     state_r, state_nxt;
  logic [PB_W-1:0] cur_r, cur_nxt;
  logic [PB_W-1:0] end_byte_r, end_byte_nxt;
  logic [PB_W-1:0] first_byte_r, first_byte_nxt;
  logic [PB_W-1:0] last_byte_r, last_byte_nxt;
  logic [2:0]      first_lo_r, first_lo_nxt;
  logic [2:0]      last_hi_r, last_hi_nxt;
  logic            deny_r, deny_nxt;
  logic            q_in_map_r, q_in_map_nxt;
  logic            clr_resp_r, clr_resp_nxt;
  logic            res_r, res_nxt;
  logic            wb_pend_r, wb_pend_nxt;
  logic [PB_W-1:0] wb_addr_r, wb_addr_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_allowed_r, out_allowed_nxt;

  logic [7:0]        mem_r [BITMAP_BYTES];
  logic [7:0]        rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;

  logic            in_fire;
  logic [PB_W-1:0] in_fb, in_lb;
  logic            fb_in_map, lb_in_map;
  logic [2:0]      mask_lo, mask_hi;
  logic [7:0]      mask;

  assign in_ready    = (state_r == ST_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign out_valid   = out_valid_r;
  assign out_allowed = out_allowed_r;

  // byte indexes of the incoming ports
  assign in_fb     = in_start_port[PORT_W-1:3];
  assign in_lb     = in_end_port[PORT_W-1:3];
  assign fb_in_map = ({1'b0, in_fb} < MAP_LIMIT);
  assign lb_in_map = ({1'b0, in_lb} < MAP_LIMIT);

  // bit mask of the byte being written back
  assign mask_lo = (wb_addr_r == first_byte_r) ? first_lo_r : 3'd0;
  assign mask_hi = (wb_addr_r == last_byte_r) ? last_hi_r : 3'd7;
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mask[i] = (3'(i) >= mask_lo) && (3'(i) <= mask_hi);
    end
  end

  // memory port control
  always_comb begin
    rd_addr = (state_r == ST_IDLE) ? in_fb[ADDR_W-1:0] : cur_r[ADDR_W-1:0];
    mem_we  = 1'b0;
    wr_addr = cur_r[ADDR_W-1:0];
    wr_data = BYTE_DENY;
    if (state_r == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (wb_pend_r) begin
      mem_we  = 1'b1;
      wr_addr = wb_addr_r[ADDR_W-1:0];
      wr_data = deny_r ? (rd_data_r | mask) : (rd_data_r & ~mask);
    end
  end

  // byte memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  // next state and datapath
  always_comb begin
    state_nxt       = state_r;
    cur_nxt         = cur_r;
    end_byte_nxt    = end_byte_r;
    first_byte_nxt  = first_byte_r;
    last_byte_nxt   = last_byte_r;
    first_lo_nxt    = first_lo_r;
    last_hi_nxt     = last_hi_r;
    deny_nxt        = deny_r;
    q_in_map_nxt    = q_in_map_r;
    clr_resp_nxt    = clr_resp_r;
    res_nxt         = res_r;
    wb_pend_nxt     = 1'b0;
    wb_addr_nxt     = cur_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_allowed_nxt = out_allowed_r;

    unique case (state_r)
      ST_CLEAR: begin
        cur_nxt = cur_r + 1'b1;
        if (cur_r == MAP_LAST) begin
          state_nxt = clr_resp_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          res_nxt        = 1'b0;
          first_byte_nxt = in_fb;
          last_byte_nxt  = in_lb;
          first_lo_nxt   = in_start_port[2:0];
          last_hi_nxt    = in_end_port[2:0];
          cur_nxt        = in_fb;
          end_byte_nxt   = lb_in_map ? in_lb : MAP_LAST;
          deny_nxt       = (iopb_func_t'(in_func) == FN_DENY);
          q_in_map_nxt   = fb_in_map;
          unique case (iopb_func_t'(in_func))
            FN_ALLOW, FN_DENY: begin
              if ((in_start_port <= in_end_port) && fb_in_map) begin
                state_nxt = ST_WALK;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            FN_QUERY: begin
              state_nxt = ST_QUERY;
            end
            FN_CLEAR: begin
              cur_nxt      = '0;
              clr_resp_nxt = 1'b1;
              state_nxt    = ST_CLEAR;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_WALK: begin
        wb_pend_nxt = 1'b1;
        wb_addr_nxt = cur_r;
        if (cur_r == end_byte_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          cur_nxt = cur_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_QUERY: begin
        res_nxt   = q_in_map_r && !rd_data_r[first_lo_r];
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_allowed_nxt = res_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cur_r       <= '0;
      clr_resp_r  <= 1'b0;
      wb_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      clr_resp_r  <= clr_resp_nxt;
      wb_pend_r   <= wb_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    end_byte_r    <= end_byte_nxt;
    first_byte_r  <= first_byte_nxt;
    last_byte_r   <= last_byte_nxt;
    first_lo_r    <= first_lo_nxt;
    last_hi_r     <= last_hi_nxt;
    deny_r        <= deny_nxt;
    q_in_map_r    <= q_in_map_nxt;
    res_r         <= res_nxt;
    wb_addr_r     <= wb_addr_nxt;
    out_allowed_r <= out_allowed_nxt;
  end

`ifndef SYNTH
  // no memory write while waiting for a word
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mem_we)
    else $error("memory written while idle");

  // walker never passes the clamped end of the range
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> ({1'b0, cur_r} < MAP_LIMIT) && (cur_r <= end_byte_r))
    else $error("range walker beyond end byte");

  // pending write-back always follows a walk cycle
  a_wb_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    wb_pend_r |-> ($past(state_r) == ST_WALK) && (wb_addr_r == $past(cur_r)))
    else $error("write-back without matching read");

  // a finished result waits while the output word is stalled
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && !out_ready) |=> (state_r == ST_DONE))
    else $error("result dropped while output stalled");
`endif

endmodule

[verif/io_port_permission_bitmap_tb.sv]
// self-checking testbench for io_port_permission_bitmap
// tracks the expected permission map in a scoreboard class and checks every answer
// depends on iopb_pkg and io_port_permission_bitmap

module io_port_permission_bitmap_tb;
  import iopb_pkg::*;

  localparam int RANDOM_WORDS = 830;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 20;
  // the limit leaves ample room for the reset sweep, a few full-map clears and walks,
  // and the rest short words with random gaps and stalls
  localparam int CYCLE_LIMIT  = 1000000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_func;
  logic [PORT_W-1:0] in_start_port;
  logic [PORT_W-1:0] in_end_port;
  logic              out_valid;
  logic              out_ready;
  logic              out_allowed;

  // traffic shaping controls, mostly set by the stimulus process, and the run's cycle count
  bit          tx_gaps;
  bit          rx_stalls;
  bit          hold_req;
  logic [15:0] hot_base;
  int          clears_left;
  int          bigs_left;
  int          cycles;

  // expected permission map and queue of pending answers
  class permission_tracker;
    typedef struct {
      int          seq;
      iopb_func_t  op;
      logic [15:0] port;
      bit          allowed;
    } answer_t;

    logic [7:0] perm_bytes [BITMAP_BYTES];
    answer_t    answer_q [$];
    int         words_seen;
    int         answers_seen;
    int         grants;
    int         clears;
    int         faults;

    function new();
      deny_everything();
    endfunction

    function void deny_everything();
      foreach (perm_bytes[i]) perm_bytes[i] = BYTE_DENY;
    endfunction

    function bit port_mapped(int port);
      return (port >> 3) < BITMAP_BYTES;
    endfunction

    // inclusive range, no wrap past the top port
    function void write_span(int lo, int hi, bit deny);
      if (lo > hi) return;
      for (int p = lo; p <= hi && p <= 16'hFFFF; p++) begin
        if (!port_mapped(p)) continue;
        perm_bytes[p >> 3][p & 7] = deny;
      end
    endfunction

    function void note_word(iopb_func_t op, logic [15:0] lo, logic [15:0] hi);
      answer_t a;
      a.seq     = words_seen;
      a.op      = op;
      a.port    = lo;
      a.allowed = 1'b0;
      words_seen++;
      case (op)
        FN_ALLOW: write_span(lo, hi, 1'b0);
        FN_DENY:  write_span(lo, hi, 1'b1);
        FN_QUERY: if (port_mapped(lo)) a.allowed = !perm_bytes[lo >> 3][lo[2:0]];
        default: begin
          deny_everything();
          clears++;
        end
      endcase
      answer_q.push_back(a);
    endfunction

    function void check_answer(logic got);
      answer_t a;
      if (answer_q.size() == 0) begin
        faults++;
        if (faults <= 10) $display("result word with nothing pending: allowed=%b", got);
        return;
      end
      a = answer_q.pop_front();
      answers_seen++;
      if (a.op == FN_QUERY && a.allowed) grants++;
      if (got !== a.allowed) begin
        faults++;
        if (faults <= 10)
          $display("mismatch on word %0d (%s port %0d): expected allowed=%0d, got %b",
                   a.seq, a.op.name(), a.port, a.allowed, got);
      end
    endfunction

    function int pending();
      return answer_q.size();
    endfunction
  endclass

  permission_tracker tracker;

  io_port_permission_bitmap i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_start_port(in_start_port),
    .in_end_port  (in_end_port),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_allowed  (out_allowed)
  );

  always #5 clk = ~clk;

  // watch both handshakes at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        tracker.note_word(iopb_func_t'(in_func), in_start_port, in_end_port);
      if (out_valid && out_ready)
        tracker.check_answer(out_allowed);
    end
  end

  // result side: random stall bursts and one long hold on request
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // run limit
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d answers still pending", cycles, tracker.pending());
    $display("[FAIL] regression broken");
    $finish;
  end

  // offer one word, optionally after a gap, and hold it until accepted
  task automatic send_word(input iopb_func_t op, input logic [15:0] lo,
                           input logic [15:0] hi);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= op;
    in_start_port <= lo;
    in_end_port   <= hi;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  // stop offering until every answer is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  // mostly short ranges and queries around a moving neighborhood
  task automatic pick_word(output iopb_func_t op, output logic [15:0] lo,
                           output logic [15:0] hi);
    int roll;
    int span;
    int shape;
    roll  = $urandom_range(0, 999);
    shape = $urandom_range(0, 99);
    if ($urandom_range(0, 31) == 0)
      hot_base = ($urandom_range(0, 5) == 0) ? 16'hFFC0 : 16'($urandom);
    lo   = hot_base + 16'($urandom_range(0, 63));
    span = $urandom_range(0, 40);
    hi   = (int'(lo) + span > 65535) ? 16'hFFFF : lo + 16'(span);
    if (roll < 450) begin
      op = FN_QUERY;
      hi = 16'($urandom);
    end else if (roll < 990 || clears_left == 0) begin
      op = (roll < 720) ? FN_ALLOW : FN_DENY;
      if (roll >= 990) op = FN_QUERY;
      if (op != FN_QUERY) begin
        if (shape < 5) begin
          // reversed range
          hi = 16'($urandom_range(0, 65534));
          lo = hi + 16'($urandom_range(1, 65535 - int'(hi)));
        end else if (shape < 9) begin
          lo   = 16'($urandom);
          span = $urandom_range(0, 20);
          hi   = (int'(lo) + span > 65535) ? 16'hFFFF : lo + 16'(span);
        end else if (shape == 9 && bigs_left > 0) begin
          bigs_left--;
          lo = 16'($urandom_range(0, 4095));
          hi = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom_range(60000, 65535));
        end
      end
    end else begin
      clears_left--;
      op = FN_CLEAR;
      hi = 16'($urandom);
      lo = 16'($urandom);
    end
  endtask

  // stimulus
  initial begin
    iopb_func_t  op;
    logic [15:0] lo;
    logic [15:0] hi;
    tracker       = new();
    tx_gaps       = 1'b0;
    rx_stalls     = 1'b0;
    hold_req      = 1'b0;
    hot_base      = 16'd0;
    clears_left   = 5;
    bigs_left     = 6;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_func       <= FN_ALLOW;
    in_start_port <= '0;
    in_end_port   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: edges of the port range, single ports, reversed ranges, full map
    send_word(FN_QUERY, 16'd0, 16'd0);
    send_word(FN_QUERY, 16'hFFFF, 16'hFFFF);
    send_word(FN_ALLOW, 16'd0, 16'd0);
    send_word(FN_QUERY, 16'd0, 16'hFFFF);
    send_word(FN_QUERY, 16'd1, 16'd0);
    send_word(FN_ALLOW, 16'hFFFF, 16'hFFFF);
    send_word(FN_QUERY, 16'hFFFF, 16'd0);
    send_word(FN_ALLOW, 16'd100, 16'd50);
    send_word(FN_QUERY, 16'd75, 16'd0);
    send_word(FN_ALLOW, 16'd8, 16'd23);
    send_word(FN_QUERY, 16'd15, 16'd0);
    send_word(FN_QUERY, 16'd24, 16'd0);
    send_word(FN_DENY, 16'd10, 16'd12);
    send_word(FN_QUERY, 16'd11, 16'd0);
    send_word(FN_QUERY, 16'd13, 16'd0);
    send_word(FN_ALLOW, 16'd65530, 16'hFFFF);
    send_word(FN_QUERY, 16'd65532, 16'd0);
    send_word(FN_CLEAR, 16'hFFFF, 16'hAAAA);
    send_word(FN_QUERY, 16'd65532, 16'd0);
    send_word(FN_ALLOW, 16'd0, 16'hFFFF);
    send_word(FN_QUERY, 16'd40000, 16'd0);
    send_word(FN_DENY, 16'hFFFF, 16'd0);
    send_word(FN_QUERY, 16'd12345, 16'h5555);
    send_word(FN_DENY, 16'd0, 16'hFFFF);
    send_word(FN_QUERY, 16'd40000, 16'd0);

    // random words with phased idling; quiet tail at the end
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 64 == 0) begin
        tx_gaps   = $urandom_range(0, 2) != 0;
        rx_stalls = $urandom_range(0, 2) != 0;
      end
      if (i >= RANDOM_WORDS - 100) begin
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
      end
      // long result-side hold while words keep coming
      if (i == 300) begin
        hold_req = 1'b1;
        tx_gaps  = 1'b0;
      end
      if (i == 500) wait_drained();
      pick_word(op, lo, hi);
      send_word(op, lo, hi);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d words: %0d answers checked, %0d query grants, %0d map clears",
             tracker.words_seen, tracker.answers_seen, tracker.grants, tracker.clears);
    $display("%0d faults, %0d answers left over, %0d cycles",
             tracker.faults, tracker.pending(), cycles);
    if (tracker.faults == 0 && tracker.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/iopb_pkg.sv
sv/io_port_permission_bitmap.sv
verif/io_port_permission_bitmap_tb.sv
